[rtl/sql_keyword_stream_detector_macros.svh]
// assertion helpers for the detector top level
`ifndef SQL_KEYWORD_STREAM_DETECTOR_MACROS_SVH
`define SQL_KEYWORD_STREAM_DETECTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SKD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/skd_pkg.sv]
`default_nettype none

package skd_pkg;

  localparam int unsigned HIST_DEPTH = 13;
  localparam int unsigned KW_COUNT   = 10;
  localparam int unsigned KW_MAXLEN  = 12;

  // keyword text, right-aligned: last character in the lowest byte
  localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    (KW_MAXLEN*8)'("AND"),
    (KW_MAXLEN*8)'("OR"),
    (KW_MAXLEN*8)'("SELECT"),
    (KW_MAXLEN*8)'("INSERT INTO"),
    (KW_MAXLEN*8)'("VALUES"),
    (KW_MAXLEN*8)'("UPDATE"),
    (KW_MAXLEN*8)'("DELETE FROM"),
    (KW_MAXLEN*8)'("UNION SELECT"),
    (KW_MAXLEN*8)'("ORDER BY"),
    (KW_MAXLEN*8)'("GROUP BY")
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{3, 2, 6, 11, 6, 6, 11, 12, 8, 8};

  localparam int unsigned FROM_LEN = 4;
  localparam logic [FROM_LEN*8-1:0] FROM_TEXT = "FROM";

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;

  // one history slot as seen by the matchers
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] ch;    // upper-case folded
    logic       word;
    logic       vld;
  } cell_t;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

[rtl/skd_cell.sv]
`default_nettype none

module skd_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [7:0]    din_byte,
  input  wire logic          din_vld,
  output skd_pkg::cell_t     q
);

  logic [7:0] byte_q;
  logic       vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_q <= din_byte;
    end
  end

  always_comb begin
    q.raw  = byte_q;
    q.ch   = skd_pkg::fold(byte_q);
    q.word = skd_pkg::is_word(byte_q);
    q.vld  = vld;
  end

endmodule

`default_nettype wire

[rtl/skd_kw_match.sv]
`default_nettype none

module skd_kw_match (
  input  wire skd_pkg::cell_t cells [skd_pkg::HIST_DEPTH],
  output logic                kw_any,
  output logic                from_hit
);

  logic [skd_pkg::KW_COUNT-1:0] kw_hit;

  // slot j holds the character j places back from the newest one
  for (genvar k = 0; k < skd_pkg::KW_COUNT; k++) begin : g_kw
    localparam int unsigned L = skd_pkg::KW_LEN[k];
    always_comb begin
      kw_hit[k] = cells[L-1].vld && !(cells[L].vld && cells[L].word);
      for (int j = 0; j < L; j++) begin
        if (cells[j].ch != skd_pkg::KW_TEXT[k][j*8 +: 8]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    from_hit = cells[skd_pkg::FROM_LEN-1].vld &&
               !(cells[skd_pkg::FROM_LEN].vld && cells[skd_pkg::FROM_LEN].word);
    for (int j = 0; j < skd_pkg::FROM_LEN; j++) begin
      if (cells[j].ch != skd_pkg::FROM_TEXT[j*8 +: 8]) begin
        from_hit = 1'b0;
      end
    end
  end

  assign kw_any = |kw_hit;

endmodule

`default_nettype wire

[rtl/sql_keyword_stream_detector.sv]
// throughput: one byte per cycle, texts back to back, unless a closed text waits on a full
// result slot; the history chain shifts every transfer. found reaches m_tdata through the
// tail flag and the output register, judged from the registered history once that holds
// the last byte and the slot is free, while the next text's first byte enters a cleared chain
// reset: synchronous, active high; empties history, clears match threads and the output slot
`default_nettype none

`include "sql_keyword_stream_detector_macros.svh"

module sql_keyword_stream_detector (
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tlast,   // end_of_text
  // result stream, one transfer per text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] found, [7:1] zero
);

  localparam int unsigned HD = skd_pkg::HIST_DEPTH;

  // from..where thread positions
  localparam int unsigned FW_WS   = 0;  // whitespace run after "FROM "
  localparam int unsigned FW_WORD = 1;  // word run
  localparam int unsigned FW_P0   = 2;  // after the space before WHERE
  localparam int unsigned FW_P1   = 3;
  localparam int unsigned FW_P2   = 4;
  localparam int unsigned FW_P3   = 5;
  localparam int unsigned FW_P4   = 6;
  localparam int unsigned FW_P5   = 7;  // WHERE complete, waits for a boundary

  skd_pkg::cell_t cq       [HD];
  logic [7:0]     cin_byte [HD];
  logic           cin_vld  [HD];

  logic [7:0] fw_state;
  logic [7:0] fw_next;
  logic       found_flag;
  logic       found_next;
  logic       tail;        // last byte of a text sits in the history
  logic       out_valid;
  logic       out_found;

  logic       accept;
  logic       out_free;
  logic       finish;
  logic       kw_any;
  logic       from_hit;
  logic       hit_now;     // a pattern ends at the newest history byte

  logic [7:0] in_fold;
  logic       in_word;
  logic       in_space;
  logic       in_sp;
  logic       thread_w;

  assign out_free = !out_valid || m_tready;
  assign s_tready = !tail || out_free;
  assign accept   = s_tvalid && s_tready;
  assign finish   = tail && out_free;

  // ------------------------------------------------------------------
  // history chain: newest byte in cell 0, each transfer moves all one
  // step on; closing a text empties every cell behind the new byte
  // ------------------------------------------------------------------
  assign cin_byte[0] = s_tdata;
  assign cin_vld[0]  = accept;

  for (genvar i = 1; i < HD; i++) begin : g_link
    assign cin_byte[i] = cq[i-1].raw;
    assign cin_vld[i]  = cq[i-1].vld && !finish;
  end

  for (genvar i = 0; i < HD; i++) begin : g_cell
    skd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (accept || finish),
      .din_byte (cin_byte[i]),
      .din_vld  (cin_vld[i]),
      .q        (cq[i])
    );
  end

  skd_kw_match u_match (
    .cells    (cq),
    .kw_any   (kw_any),
    .from_hit (from_hit)
  );

  assign hit_now = kw_any || fw_state[FW_P5];

  // ------------------------------------------------------------------
  // from..where threads and the sticky flag, driven by the incoming byte
  // ------------------------------------------------------------------
  assign in_fold  = skd_pkg::fold(s_tdata);
  assign in_word  = skd_pkg::is_word(s_tdata);
  assign in_space = skd_pkg::is_space(s_tdata);
  assign in_sp    = (s_tdata == skd_pkg::CH_SPACE);
  assign thread_w = fw_state[FW_WS] || fw_state[FW_WORD];

  always_comb begin
    fw_next          = '0;
    fw_next[FW_WS]   = (fw_state[FW_WS] && in_space) || (in_sp && from_hit);
    fw_next[FW_WORD] = thread_w && in_word;
    fw_next[FW_P0]   = thread_w && in_sp;
    fw_next[FW_P1]   = fw_state[FW_P0] && (in_fold == skd_pkg::CH_W);
    fw_next[FW_P2]   = fw_state[FW_P1] && (in_fold == skd_pkg::CH_H);
    fw_next[FW_P3]   = fw_state[FW_P2] && (in_fold == skd_pkg::CH_E);
    fw_next[FW_P4]   = fw_state[FW_P3] && (in_fold == skd_pkg::CH_R);
    fw_next[FW_P5]   = fw_state[FW_P4] && (in_fold == skd_pkg::CH_E);
  end

  // a non-word byte closes whatever ended on the byte before it
  assign found_next = found_flag || (!in_word && hit_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_state   <= '0;
      found_flag <= 1'b0;
      tail       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (finish) begin
        // new text starts from an empty history, so no thread can open yet
        fw_state   <= '0;
        found_flag <= 1'b0;
        tail       <= accept && s_tlast;
      end else if (accept) begin
        fw_state   <= fw_next;
        found_flag <= found_next;
        tail       <= s_tlast;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // end of text counts as the closing boundary
  always_ff @(posedge clk) begin
    if (finish) begin
      out_found <= found_flag || hit_now;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_found};

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `SKD_ASSERT_IMPL(a_result_after_tail, $rose(m_tvalid), $past(tail), "result without a closed text")
  `SKD_ASSERT_IMPL(a_stall_on_full, tail && !out_free, !s_tready, "byte taken while text close is blocked")
  `SKD_ASSERT_NEXT(a_clear_on_close, finish && !accept, !cq[0].vld, "history kept after text close")
  `SKD_ASSERT_IMPL(a_thread_needs_hist, fw_state != 8'd0, cq[0].vld, "thread active on empty history")

endmodule

`default_nettype wire

[sim/sql_keyword_stream_detector_tb.sv]
`default_nettype none

module sql_keyword_stream_detector_tb;

  // match-thread positions of the FROM .. WHERE pattern (bit indexes)
  localparam int FW_WS   = 0;  // whitespace run after "FROM "
  localparam int FW_WORD = 1;  // word run
  localparam int FW_SP   = 2;  // after the space before WHERE
  localparam int FW_W    = 3;
  localparam int FW_H    = 4;
  localparam int FW_E    = 5;
  localparam int FW_R    = 6;
  localparam int FW_DONE = 7;  // WHERE seen, closing boundary pending

  localparam int           DEPTH       = 13;
  localparam logic [7:0]   SP          = 8'h20;
  localparam int           TOTAL_BYTES = 1600;
  localparam int           QUIET_FROM  = 500;
  localparam int           QUIET_TO    = 900;
  localparam int           LIMIT       = 400000;
  localparam int           MAX_REPORTS = 10;

  // tracks keyword hits per text and holds the found verdicts still owed
  class keyword_hit_tracker;
    logic [7:0] hist [DEPTH];
    int         fill;
    bit   [7:0] fw;
    bit         hit;
    bit         verdicts [$];
    string      keywords [10];
    int         errors;

    function new();
      keywords = '{"AND", "OR", "SELECT", "INSERT INTO", "VALUES", "UPDATE",
                   "DELETE FROM", "UNION SELECT", "ORDER BY", "GROUP BY"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = '0;
      fill = 0;
      fw   = '0;
      hit  = 1'b0;
    endfunction

    function bit word_ch(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function bit space_ch(logic [7:0] c);
      return c == SP || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic [7:0] upper(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // history ends in k (newest char last in k) with a word boundary in front
    function bit tail_is(string k);
      int n;
      n = k.len();
      if (n == 0 || n >= DEPTH || fill < n) return 1'b0;
      for (int i = 0; i < n; i++)
        if (upper(hist[n-1-i]) != k[i]) return 1'b0;
      if (fill > n && word_ch(hist[n])) return 1'b0;
      return 1'b1;
    endfunction

    function bit any_keyword();
      foreach (keywords[i])
        if (tail_is(keywords[i])) return 1'b1;
      return 1'b0;
    endfunction

    // one accepted input transfer
    function void note_byte(logic [7:0] b, bit last);
      bit   [7:0] nxt;
      logic [7:0] f;
      nxt = '0;
      f   = upper(b);
      // a non-word byte closes whatever ended on the previous byte
      if (!word_ch(b) && (any_keyword() || fw[FW_DONE])) hit = 1'b1;
      if (fw[FW_WS]) begin
        if (space_ch(b)) nxt[FW_WS]   = 1'b1;
        if (word_ch(b))  nxt[FW_WORD] = 1'b1;
        if (b == SP)     nxt[FW_SP]   = 1'b1;
      end
      if (fw[FW_WORD]) begin
        if (word_ch(b)) nxt[FW_WORD] = 1'b1;
        if (b == SP)    nxt[FW_SP]   = 1'b1;
      end
      if (fw[FW_SP] && f == "W") nxt[FW_W]    = 1'b1;
      if (fw[FW_W]  && f == "H") nxt[FW_H]    = 1'b1;
      if (fw[FW_H]  && f == "E") nxt[FW_E]    = 1'b1;
      if (fw[FW_E]  && f == "R") nxt[FW_R]    = 1'b1;
      if (fw[FW_R]  && f == "E") nxt[FW_DONE] = 1'b1;
      if (b == SP && tail_is("FROM")) nxt[FW_WS] = 1'b1;
      fw = nxt;
      for (int i = DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = b;
      if (fill < DEPTH) fill++;
      if (last) begin
        // end of text counts as the closing boundary
        if (any_keyword() || fw[FW_DONE]) hit = 1'b1;
        verdicts.push_back(hit);
        clear();
      end
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // one accepted result transfer
    function void check_verdict(logic [7:0] tdata);
      bit want;
      if (verdicts.size() == 0) begin
        fail($sformatf("unexpected result transfer, tdata %02h", tdata));
        return;
      end
      want = verdicts.pop_front();
      if (tdata !== {7'b0, want})
        fail($sformatf("found mismatch: expected %0b, got tdata %02h", want, tdata));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  keyword_hit_tracker tracker;
  logic [7:0]         text_q [$];
  int                 bytes_sent = 0;
  bit                 quiet = 1'b0;   // no idling on either side while set
  int                 cycle_cnt = 0;

  sql_keyword_stream_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, quiet window excepted
  always @(negedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_verdict(m_tdata);
  end

  // ---------------------------------------------------------------- text building

  // letters come out in random case
  function automatic logic [7:0] any_case(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) return c + 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_word_ch();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return 8'h5F;
  endfunction

  function automatic logic [7:0] rand_ws();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? SP : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] rand_sep();
    string punct;
    punct = ",;()=*'-.";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SP;
      4:          return rand_ws();
      5:          return punct[$urandom_range(0, punct.len() - 1)];
      6:          return 8'h00;
      7:          return 8'($urandom_range(128, 255));
      8:          return 8'($urandom_range(0, 31));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_str(string s, bit mix);
    for (int i = 0; i < s.len(); i++) text_q.push_back(mix ? any_case(s[i]) : s[i]);
  endtask

  // keyword, sometimes spoiled by a changed or dropped letter or a glued word char
  task automatic push_keyword();
    logic [7:0] kq [$];
    string      k;
    int         pos;
    k = tracker.keywords[$urandom_range(0, 9)];
    for (int i = 0; i < k.len(); i++) kq.push_back(k[i]);
    if ($urandom_range(99) < 25) begin
      pos = $urandom_range(0, kq.size() - 1);
      case ($urandom_range(0, 3))
        0: kq[pos] = 8'h41 + 8'($urandom_range(0, 25));
        1: kq.delete(pos);
        2: kq.push_front(rand_word_ch());
        default: kq.push_back(rand_word_ch());
      endcase
    end
    foreach (kq[i]) text_q.push_back(any_case(kq[i]));
  endtask

  // FROM <sp> [ws] [word] <sp> WHERE, now and then with a broken joint
  task automatic push_from_where();
    push_str("FROM", 1'b1);
    text_q.push_back(($urandom_range(99) < 85) ? SP : rand_ws());
    repeat ($urandom_range(0, 3)) text_q.push_back(rand_ws());
    if ($urandom_range(1)) repeat ($urandom_range(1, 4)) text_q.push_back(rand_word_ch());
    if ($urandom_range(99) < 85) text_q.push_back(SP);
    else if ($urandom_range(1)) text_q.push_back(rand_ws());
    push_str("WHERE", 1'b1);
  endtask

  task automatic make_text();
    int r;
    text_q.delete();
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 99);
      if (r < 35)      push_keyword();
      else if (r < 55) push_from_where();
      else if (r < 75) repeat ($urandom_range(1, 5)) text_q.push_back(rand_word_ch());
      else if (r < 90) repeat ($urandom_range(1, 3)) text_q.push_back(rand_sep());
      else             repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      // usually a separator between tokens, sometimes glued
      if ($urandom_range(99) < 80) text_q.push_back(rand_sep());
    end
    if ($urandom_range(1)) void'(text_q.pop_back());
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      @(negedge clk);
      while (!quiet && $urandom_range(99) < 7) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text_q[i];
      s_tlast  <= (i == text_q.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      tracker.note_byte(text_q[i], i == text_q.size() - 1);
      bytes_sent++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: byte extremes as one-byte texts, a bare keyword, a glued one,
    // keyword framed by NUL and non-ASCII bytes, FROM .. WHERE with empty runs
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();
    text_q.delete();
    push_str("oR", 1'b0);
    send_text();
    text_q.delete();
    push_str("xand", 1'b0);
    send_text();
    text_q = '{8'hFF};
    push_str("and", 1'b0);
    text_q.push_back(8'h00);
    send_text();
    text_q.delete();
    push_str("from  Where", 1'b0);
    send_text();

    // random texts, mostly well-formed patterns with random content
    while (bytes_sent < TOTAL_BYTES) begin
      quiet = (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO);
      make_text();
      send_text();
    end
    quiet = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (tracker.verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.errors == 0 && tracker.verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
